FILE: src/rftq_pkg.sv
// rftq_pkg: widths, register map, reset values and saturation helpers
// for the rotor force and torque step block. No dependencies.
`default_nettype none

package rftq_pkg;

    localparam int CMD_W      = 16;
    localparam int DT_W       = 16;
    localparam int THRUST_W   = 15;
    localparam int COEF_W     = 24;
    localparam int RATIO_W    = 16;
    localparam int VEC_W      = 48;
    localparam int COMP_W     = 16;
    localparam int FORCE_W    = 16;
    localparam int TORQUE_W   = 24;
    localparam int SPEED_W    = 21;
    localparam int PHASE_W    = 48;

    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 192;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    // widest root the radicand can produce
    localparam int ROOT_MAX_BITS     = 20;
    localparam int SQRT_BITS_DEFAULT = 20;
    // multiplier schedule length inside the root loop
    localparam int SCHED_LEN         = 13;

    localparam logic [THRUST_W-1:0] MAX_THRUST_RST = 15'd1280;
    localparam logic [COEF_W-1:0]   INV_COEF_RST   = 24'd100000;
    localparam logic [RATIO_W-1:0]  RATIO_RST      = 16'd0;
    localparam logic [VEC_W-1:0]    POSITION_RST   = 48'd0;
    localparam logic [VEC_W-1:0]    DIRECTION_RST  = 48'hC000_0000_0000;

    typedef enum logic [2:0] {
        REG_MAX_THRUST = 3'd0,
        REG_INV_COEF   = 3'd1,
        REG_RATIO      = 3'd2,
        REG_POSITION   = 3'd3,
        REG_DIRECTION  = 3'd4,
        REG_SPINS_CCW  = 3'd5,
        REG_FLIPPED    = 3'd6
    } cfg_idx_t;

    function automatic logic signed [FORCE_W-1:0] sat_force(input logic signed [32:0] v);
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        hi = 33'sd32767;
        lo = -33'sd32768;
        if (v > hi) begin
            sat_force = 16'sh7FFF;
        end else if (v < lo) begin
            sat_force = 16'sh8000;
        end else begin
            sat_force = v[FORCE_W-1:0];
        end
    endfunction

    function automatic logic signed [TORQUE_W-1:0] sat_torque(input logic signed [40:0] v);
        logic signed [40:0] hi;
        logic signed [40:0] lo;
        hi = 41'sd8388607;
        lo = -41'sd8388608;
        if (v > hi) begin
            sat_torque = 24'sh7FFFFF;
        end else if (v < lo) begin
            sat_torque = 24'sh800000;
        end else begin
            sat_torque = v[TORQUE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/rotor_force_torque_step.sv
// rotor_force_torque_step: rotor thrust, speed, phase, force and torque per request.
// Depends on rftq_pkg for widths, register map and saturation helpers.
`default_nettype none

// One request is taken while s_tready is high, then the block is busy. A request
// goes through one shared 25x17 signed multiplier and a bit-serial square root:
// the radicand product, a load of the root unit, the root steps that give the
// R = min(SQRT_BITS, 20) root bits and go on while the multiplier schedule runs
// (the force and torque products run on the multiplier during these steps), then
// speed and phase, and a load of the output register. A new request is taken only
// after that load. The result waits in an output register and the block goes on
// only once that register is free.
module rotor_force_torque_step #(
    parameter int SQRT_BITS = rftq_pkg::SQRT_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // thrust_command [15:0], time_step [31:16]
    input  wire logic [rftq_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // force_x [15:0], force_y [31:16], force_z [47:32], torque_x [71:48],
    // torque_y [95:72], torque_z [119:96], rotor_speed [140:120],
    // rotor_phase [188:141], zero fill [191:189]
    output logic [rftq_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rftq_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rftq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rftq_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int RW      = (SQRT_BITS < rftq_pkg::ROOT_MAX_BITS) ? SQRT_BITS
                                                                   : rftq_pkg::ROOT_MAX_BITS;
    localparam int RAD_LEN = 2 * RW;
    localparam int RUN_LEN = (RW > rftq_pkg::SCHED_LEN) ? RW : rftq_pkg::SCHED_LEN;
    localparam int CNT_W   = $clog2(RUN_LEN + 1);
    localparam int A_W     = 25;
    localparam int B_W     = 17;
    localparam int P_W     = A_W + B_W;
    localparam int ACC_W   = 40;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RAD, ST_LOAD, ST_RUN, ST_PHM, ST_PHA, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        K_NONE, K_RAD, K_FORCE, K_CROSS_A, K_CROSS_B, K_RATIO, K_PHASE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  axis;
    } mop_t;

    // configuration registers
    logic [rftq_pkg::THRUST_W-1:0] max_thrust_reg;
    logic [rftq_pkg::COEF_W-1:0]   inv_coef_reg;
    logic [rftq_pkg::RATIO_W-1:0]  ratio_reg;
    logic [rftq_pkg::VEC_W-1:0]    position_reg;
    logic [rftq_pkg::VEC_W-1:0]    direction_reg;
    logic                          spins_ccw_reg;
    logic                          flipped_reg;

    logic                          cfg_wr;
    rftq_pkg::cfg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = rftq_pkg::cfg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_thrust_reg <= rftq_pkg::MAX_THRUST_RST;
            inv_coef_reg   <= rftq_pkg::INV_COEF_RST;
            ratio_reg      <= rftq_pkg::RATIO_RST;
            position_reg   <= rftq_pkg::POSITION_RST;
            direction_reg  <= rftq_pkg::DIRECTION_RST;
            spins_ccw_reg  <= 1'b0;
            flipped_reg    <= 1'b0;
        end else if (cfg_wr && pready) begin
            case (cfg_idx)
                rftq_pkg::REG_MAX_THRUST: max_thrust_reg <= pwdata[rftq_pkg::THRUST_W-1:0];
                rftq_pkg::REG_INV_COEF:   inv_coef_reg   <= pwdata[rftq_pkg::COEF_W-1:0];
                rftq_pkg::REG_RATIO:      ratio_reg      <= pwdata[rftq_pkg::RATIO_W-1:0];
                rftq_pkg::REG_POSITION:   position_reg   <= pwdata[rftq_pkg::VEC_W-1:0];
                rftq_pkg::REG_DIRECTION:  direction_reg  <= pwdata[rftq_pkg::VEC_W-1:0];
                rftq_pkg::REG_SPINS_CCW:  spins_ccw_reg  <= pwdata[0];
                rftq_pkg::REG_FLIPPED:    flipped_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            rftq_pkg::REG_MAX_THRUST: prdata = 64'(max_thrust_reg);
            rftq_pkg::REG_INV_COEF:   prdata = 64'(inv_coef_reg);
            rftq_pkg::REG_RATIO:      prdata = 64'(ratio_reg);
            rftq_pkg::REG_POSITION:   prdata = 64'(position_reg);
            rftq_pkg::REG_DIRECTION:  prdata = 64'(direction_reg);
            rftq_pkg::REG_SPINS_CCW:  prdata = 64'(spins_ccw_reg);
            rftq_pkg::REG_FLIPPED:    prdata = 64'(flipped_reg);
            default:                  prdata = '0;
        endcase
    end

    // vector components
    logic signed [rftq_pkg::COMP_W-1:0] pos [3];
    logic signed [rftq_pkg::COMP_W-1:0] dir [3];

    assign pos[0] = position_reg[15:0];
    assign pos[1] = position_reg[31:16];
    assign pos[2] = position_reg[47:32];
    assign dir[0] = direction_reg[15:0];
    assign dir[1] = direction_reg[31:16];
    assign dir[2] = direction_reg[47:32];

    // datapath state
    state_t                              state_reg;
    logic [CNT_W-1:0]                    cnt_reg;
    logic [rftq_pkg::THRUST_W-1:0]       t_reg;
    logic [rftq_pkg::DT_W-1:0]           dt_reg;
    logic [RAD_LEN-1:0]                  rad_sh_reg;
    logic [RW+1:0]                       rem_reg;
    logic [RW-1:0]                       root_reg;
    logic                                ovf_reg;
    logic signed [P_W-1:0]               prod_reg;
    mop_t                                op_reg;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [rftq_pkg::FORCE_W-1:0] f_reg [3];
    logic signed [rftq_pkg::TORQUE_W-1:0] tq_reg [3];
    logic signed [rftq_pkg::SPEED_W-1:0] speed_reg;
    logic [rftq_pkg::PHASE_W-1:0]        phase_reg;
    logic                                m_tvalid_reg;
    logic [rftq_pkg::M_DATA_W-1:0]       m_tdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // thrust clamp on the incoming request
    logic signed [rftq_pkg::CMD_W-1:0]   cmd_in;
    logic [rftq_pkg::THRUST_W-1:0]       t_in;

    assign cmd_in = s_tdata[15:0];

    always_comb begin
        if (cmd_in[rftq_pkg::CMD_W-1]) begin
            t_in = '0;
        end else if (cmd_in[rftq_pkg::THRUST_W-1:0] > max_thrust_reg) begin
            t_in = max_thrust_reg;
        end else begin
            t_in = cmd_in[rftq_pkg::THRUST_W-1:0];
        end
    end

    function automatic logic [RW+1:0] rem_next_sub(input logic [RW+3:0] a,
                                                   input logic [RW+3:0] b);
        logic [RW+3:0] d;
        d = a - b;
        rem_next_sub = d[RW+1:0];
    endfunction

    // square root step, two radicand bits a cycle
    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic          root_ge;
    logic [RW+1:0] rem_next;
    logic [RW-1:0] root_next;

    assign rem_sh    = {rem_reg, rad_sh_reg[RAD_LEN-1 -: 2]};
    assign trial     = (RW+4)'({root_reg, 2'b01});
    assign root_ge   = (rem_sh >= trial);
    assign rem_next  = root_ge ? rem_next_sub(rem_sh, trial) : rem_sh[RW+1:0];
    assign root_next = {root_reg[RW-2:0], root_ge};

    // signed speed from the (limited) root
    logic [RW-1:0]                       root_sat;
    logic signed [rftq_pkg::SPEED_W-1:0] root_ext;
    logic signed [rftq_pkg::SPEED_W-1:0] speed_now;

    assign root_sat  = ovf_reg ? {RW{1'b1}} : root_reg;
    assign root_ext  = rftq_pkg::SPEED_W'(root_sat);
    assign speed_now = spins_ccw_reg ? root_ext : -root_ext;

    // multiplier issue
    mop_t                  mop_issue;
    logic [1:0]            sel_p;
    logic [1:0]            sel_f;
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;

    always_comb begin
        mop_issue = '{kind: K_NONE, axis: 2'd0};
        sel_p     = 2'd0;
        sel_f     = 2'd0;
        case (state_reg)
            ST_RAD: begin
                mop_issue.kind = K_RAD;
            end
            ST_RUN: begin
                case (cnt_reg)
                    CNT_W'(0):  mop_issue = '{kind: K_FORCE,   axis: 2'd0};
                    CNT_W'(1):  mop_issue = '{kind: K_FORCE,   axis: 2'd1};
                    CNT_W'(2):  mop_issue = '{kind: K_FORCE,   axis: 2'd2};
                    CNT_W'(4): begin
                        mop_issue = '{kind: K_CROSS_A, axis: 2'd0};
                        sel_p = 2'd1; sel_f = 2'd2;
                    end
                    CNT_W'(5): begin
                        mop_issue = '{kind: K_CROSS_B, axis: 2'd0};
                        sel_p = 2'd2; sel_f = 2'd1;
                    end
                    CNT_W'(6): begin
                        mop_issue = '{kind: K_RATIO,   axis: 2'd0};
                        sel_f = 2'd0;
                    end
                    CNT_W'(7): begin
                        mop_issue = '{kind: K_CROSS_A, axis: 2'd1};
                        sel_p = 2'd2; sel_f = 2'd0;
                    end
                    CNT_W'(8): begin
                        mop_issue = '{kind: K_CROSS_B, axis: 2'd1};
                        sel_p = 2'd0; sel_f = 2'd2;
                    end
                    CNT_W'(9): begin
                        mop_issue = '{kind: K_RATIO,   axis: 2'd1};
                        sel_f = 2'd1;
                    end
                    CNT_W'(10): begin
                        mop_issue = '{kind: K_CROSS_A, axis: 2'd2};
                        sel_p = 2'd0; sel_f = 2'd1;
                    end
                    CNT_W'(11): begin
                        mop_issue = '{kind: K_CROSS_B, axis: 2'd2};
                        sel_p = 2'd1; sel_f = 2'd0;
                    end
                    CNT_W'(12): begin
                        mop_issue = '{kind: K_RATIO,   axis: 2'd2};
                        sel_f = 2'd2;
                    end
                    default: ;
                endcase
            end
            ST_PHM: begin
                mop_issue.kind = K_PHASE;
            end
            default: ;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mop_issue.kind)
            K_RAD: begin
                mul_a = A_W'(inv_coef_reg);
                mul_b = B_W'(t_reg);
            end
            K_FORCE: begin
                mul_a = A_W'(dir[mop_issue.axis]);
                mul_b = B_W'(t_reg);
            end
            K_CROSS_A, K_CROSS_B: begin
                mul_a = A_W'(pos[sel_p]);
                mul_b = B_W'(f_reg[sel_f]);
            end
            K_RATIO: begin
                mul_a = A_W'(f_reg[sel_f]);
                mul_b = B_W'(ratio_reg);
            end
            K_PHASE: begin
                mul_a = A_W'(speed_now);
                mul_b = B_W'(dt_reg);
            end
            default: ;
        endcase
    end

    // product post-processing
    logic signed [31:0]                   fprod;
    logic signed [32:0]                   fv;
    logic signed [32:0]                   fr;
    logic signed [ACC_W-1:0]              tmag;
    logic signed [ACC_W-1:0]              term;
    logic                                 term_neg;
    logic signed [ACC_W-1:0]              sum;
    logic signed [ACC_W:0]                sum_rnd;
    logic signed [ACC_W:0]                sum_sh;
    logic signed [37:0]                   phase_prod;

    assign fprod   = prod_reg[31:0];
    assign fv      = flipped_reg ? -(33'(fprod)) : 33'(fprod);
    assign fr      = (fv + 33'sd8192) >>> 14;

    // cross terms move from Q.20 to Q.24
    assign tmag     = (op_reg.kind == K_RATIO) ? prod_reg[ACC_W-1:0] : {prod_reg[35:0], 4'b0000};
    assign term_neg = (op_reg.kind == K_CROSS_B) ||
                      ((op_reg.kind == K_RATIO) && (spins_ccw_reg != flipped_reg));
    assign term     = term_neg ? -tmag : tmag;
    assign sum      = acc_reg + term;
    assign sum_rnd  = (ACC_W+1)'(sum) + 41'sd32768;
    assign sum_sh   = sum_rnd >>> 16;

    assign phase_prod = prod_reg[37:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            op_reg       <= '{kind: K_NONE, axis: 2'd0};
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            op_reg   <= mop_issue;
            prod_reg <= mul_a * mul_b;

            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tdata_reg  <= {3'b000, phase_reg, speed_reg,
                                 tq_reg[2], tq_reg[1], tq_reg[0],
                                 f_reg[2], f_reg[1], f_reg[0]};
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (op_reg.kind)
                K_FORCE:   f_reg[op_reg.axis]  <= rftq_pkg::sat_force(fr);
                K_CROSS_A: acc_reg             <= term;
                K_CROSS_B: acc_reg             <= sum;
                K_RATIO:   tq_reg[op_reg.axis] <= rftq_pkg::sat_torque(sum_sh);
                K_PHASE:   phase_reg           <= phase_reg + rftq_pkg::PHASE_W'(phase_prod);
                default: ;
            endcase

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        t_reg     <= t_in;
                        dt_reg    <= s_tdata[31:16];
                        state_reg <= ST_RAD;
                    end
                end
                ST_RAD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    rad_sh_reg <= prod_reg[RAD_LEN-1:0];
                    // root beyond RW bits saturates
                    ovf_reg    <= |(prod_reg[39:0] >> RAD_LEN);
                    rem_reg    <= '0;
                    root_reg   <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= ST_RUN;
                end
                ST_RUN: begin
                    if (cnt_reg < CNT_W'(RW)) begin
                        rem_reg    <= rem_next;
                        root_reg   <= root_next;
                        rad_sh_reg <= {rad_sh_reg[RAD_LEN-3:0], 2'b00};
                    end
                    if (cnt_reg == CNT_W'(RUN_LEN - 1)) begin
                        state_reg <= ST_PHM;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_PHM: begin
                    speed_reg <= speed_now;
                    state_reg <= ST_PHA;
                end
                ST_PHA: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a taken request keeps the block busy for the next cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a previous one is in flight");

    // phase accumulation lines up with the phase product
    a_phase_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PHA |-> op_reg.kind == K_PHASE)
        else $error("phase product not in the accumulate slot");

    // root loop counter stays inside its run
    a_run_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> cnt_reg <= CNT_W'(RUN_LEN - 1))
        else $error("root loop counter out of range");

    // a result is only offered after the output slot
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result offered outside the output slot");

endmodule

`default_nettype wire

FILE: sim/rotor_step_checker.sv
`timescale 1ns / 1ps
// rotor_step_checker: watches the request, result and register ports of
// rotor_force_torque_step, predicts each result and compares it field by field.
// Depends on rftq_pkg for widths and the register map.

module rotor_step_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [rftq_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [rftq_pkg::M_DATA_W-1:0]     m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic                              pready,
    input  wire logic [rftq_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rftq_pkg::APB_DATA_W-1:0]   pwdata,
    output int                                     fail_count,
    output int                                     pending
);
    import rftq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // same layout as m_tdata, highest field first
    typedef struct packed {
        logic [2:0]                 fill;
        logic signed [PHASE_W-1:0]  phase;
        logic signed [SPEED_W-1:0]  speed;
        logic signed [TORQUE_W-1:0] torque_z;
        logic signed [TORQUE_W-1:0] torque_y;
        logic signed [TORQUE_W-1:0] torque_x;
        logic signed [FORCE_W-1:0]  force_z;
        logic signed [FORCE_W-1:0]  force_y;
        logic signed [FORCE_W-1:0]  force_x;
    } rotor_result_t;

    rotor_result_t expected_outputs[$];

    logic [THRUST_W-1:0] max_thrust_q;
    logic [COEF_W-1:0]   inv_coef_q;
    logic [RATIO_W-1:0]  ratio_q;
    logic [VEC_W-1:0]    pos_q;
    logic [VEC_W-1:0]    dir_q;
    logic                ccw_q;
    logic                flip_q;
    logic [PHASE_W-1:0]  phase_q;
    int                  errors = 0;

    function automatic longint saturate(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint int_sqrt(input longint radicand);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_MAX_BITS - 1; b >= 0; b--) begin
            trial = root | (longint'(1) <<< b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // expected result of one request; advances the phase copy
    function automatic rotor_result_t rotor_step_outputs(input logic [S_DATA_W-1:0] req);
        rotor_result_t r;
        longint cmd;
        longint dt;
        longint thrust;
        longint root;
        longint speed;
        longint sign;
        longint ratio;
        longint prod;
        longint frc [3];
        longint pos [3];
        longint trq [3];
        cmd = longint'($signed(req[CMD_W-1:0]));
        dt  = longint'(req[S_DATA_W-1:CMD_W]);
        if (cmd < 0) begin
            thrust = 0;
        end else if (cmd > longint'(max_thrust_q)) begin
            thrust = longint'(max_thrust_q);
        end else begin
            thrust = cmd;
        end
        root  = int_sqrt(thrust * longint'(inv_coef_q));
        speed = ccw_q ? root : -root;
        phase_q = phase_q + PHASE_W'(speed * dt);
        for (int i = 0; i < 3; i++) begin
            prod = thrust * longint'($signed(dir_q[COMP_W*i +: COMP_W]));
            if (flip_q) begin
                prod = -prod;
            end
            // Q.22 to Q8.8, round half up
            frc[i] = saturate((prod + 8192) >>> 14, FORCE_W);
            pos[i] = longint'($signed(pos_q[COMP_W*i +: COMP_W]));
        end
        sign  = (ccw_q == flip_q) ? 1 : -1;
        ratio = longint'(ratio_q);
        trq[0] = (pos[1] * frc[2] - pos[2] * frc[1]) * 16 + sign * ratio * frc[0];
        trq[1] = (pos[2] * frc[0] - pos[0] * frc[2]) * 16 + sign * ratio * frc[1];
        trq[2] = (pos[0] * frc[1] - pos[1] * frc[0]) * 16 + sign * ratio * frc[2];
        r.force_x  = FORCE_W'(frc[0]);
        r.force_y  = FORCE_W'(frc[1]);
        r.force_z  = FORCE_W'(frc[2]);
        r.torque_x = TORQUE_W'(saturate((trq[0] + 32768) >>> 16, TORQUE_W));
        r.torque_y = TORQUE_W'(saturate((trq[1] + 32768) >>> 16, TORQUE_W));
        r.torque_z = TORQUE_W'(saturate((trq[2] + 32768) >>> 16, TORQUE_W));
        r.speed    = SPEED_W'(speed);
        r.phase    = phase_q;
        r.fill     = '0;
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        rotor_result_t got;
        rotor_result_t want;
        if (!aresetn) begin
            max_thrust_q = MAX_THRUST_RST;
            inv_coef_q   = INV_COEF_RST;
            ratio_q      = RATIO_RST;
            pos_q        = POSITION_RST;
            dir_q        = DIRECTION_RST;
            ccw_q        = 1'b0;
            flip_q       = 1'b0;
            phase_q      = '0;
            expected_outputs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_MAX_THRUST: max_thrust_q = pwdata[THRUST_W-1:0];
                    REG_INV_COEF:   inv_coef_q   = pwdata[COEF_W-1:0];
                    REG_RATIO:      ratio_q      = pwdata[RATIO_W-1:0];
                    REG_POSITION:   pos_q        = pwdata[VEC_W-1:0];
                    REG_DIRECTION:  dir_q        = pwdata[VEC_W-1:0];
                    REG_SPINS_CCW:  ccw_q        = pwdata[0];
                    REG_FLIPPED:    flip_q       = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                // append at the tail
                expected_outputs.insert(expected_outputs.size(), rotor_step_outputs(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = rotor_result_t'(m_tdata);
                if (expected_outputs.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected, got %h", $realtime, m_tdata);
                    end
                end else begin
                    want = expected_outputs.pop_front();
                    compare_field("force_x", want.force_x, got.force_x);
                    compare_field("force_y", want.force_y, got.force_y);
                    compare_field("force_z", want.force_z, got.force_z);
                    compare_field("torque_x", want.torque_x, got.torque_x);
                    compare_field("torque_y", want.torque_y, got.torque_y);
                    compare_field("torque_z", want.torque_z, got.torque_z);
                    compare_field("rotor_speed", want.speed, got.speed);
                    compare_field("rotor_phase", want.phase, got.phase);
                    compare_field("zero fill", want.fill, got.fill);
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_outputs.size();
    end

endmodule

FILE: sim/tb_rotor_force_torque_step.sv
`timescale 1ns / 1ps
// tb_rotor_force_torque_step: request and register stimulus for rotor_force_torque_step
// with random idling and a long receiver hold-off. Depends on rftq_pkg and rotor_step_checker.

module tb_rotor_force_torque_step;
    import rftq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int PRESSURE_ITEMS = 30;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 108;
    localparam int SETTLE_CYCLES  = 30;
    localparam int MAX_GAP        = 40;
    localparam int REG_UNMAPPED   = 7;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // thrust_command [15:0], time_step [31:16]
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // force_x, force_y, force_z, torque_x, torque_y, torque_z, rotor_speed,
    // rotor_phase, zero fill (from bit 0 up)
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int recv_stall_pct = 0;
    int send_idle_pct  = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int unsigned cur_max = MAX_THRUST_RST;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    rotor_force_torque_step dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rotor_step_checker result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_register(input int idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_MAX_THRUST)) begin
            cur_max = value[THRUST_W-1:0];
        end
    endtask

    // returns in the time step of the edge that took the request
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DT_W-1:0] dt);
        s_tdata  <= {dt, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [CMD_W-1:0] random_command(input int unsigned limit);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            return CMD_W'($urandom_range(limit));
        end else if (pick < 45) begin
            return CMD_W'($urandom_range(limit + 2, (limit > 2) ? limit - 2 : 0));
        end else if (pick < 55) begin
            return CMD_W'($urandom_range(16));
        end else if (pick < 70) begin
            return CMD_W'(0 - $urandom_range(32768, 1));
        end
        return CMD_W'($urandom);
    endfunction

    function automatic logic [DT_W-1:0] random_step();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return '0;
        end else if (pick < 16) begin
            return '1;
        end
        return DT_W'($urandom);
    endfunction

    task automatic apply_settings(input int phase);
        logic [VEC_W-1:0] dir;
        logic [VEC_W-1:0] pos;
        int unsigned pick;
        if (phase == 0) begin
            write_register(REG_MAX_THRUST, 64'd32767);
            write_register(REG_INV_COEF, 64'd16777215);
            write_register(REG_RATIO, 64'd65535);
            write_register(REG_POSITION, 64'h7FFF_7FFF_7FFF);
            write_register(REG_DIRECTION, 64'h7FFF_7FFF_7FFF);
            write_register(REG_SPINS_CCW, 64'd1);
            write_register(REG_FLIPPED, 64'd1);
        end else if (phase == 1) begin
            write_register(REG_MAX_THRUST, 64'd32767);
            write_register(REG_INV_COEF, 64'd1);
            write_register(REG_RATIO, 64'd0);
            write_register(REG_POSITION, 64'h8000_8000_8000);
            write_register(REG_DIRECTION, 64'h8000_8000_8000);
            write_register(REG_SPINS_CCW, 64'd0);
            write_register(REG_FLIPPED, 64'd0);
        end else begin
            pick = $urandom_range(3);
            write_register(REG_MAX_THRUST, (pick == 0) ? 64'd32767 :
                           (pick == 1) ? 64'($urandom_range(4096, 256)) : 64'($urandom_range(32767)));
            pick = $urandom_range(3);
            write_register(REG_INV_COEF, (pick == 0) ? 64'd16777215 :
                           (pick == 1) ? 64'($urandom_range(200000, 1)) : 64'($urandom_range(16777215)));
            write_register(REG_RATIO, 64'($urandom_range(65535)));
            pos = {16'($urandom), 16'($urandom), 16'($urandom)};
            write_register(REG_POSITION, 64'(pos));
            // half the time each component within +/-16384, else anything
            if ($urandom_range(1) == 0) begin
                dir = {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
                       16'($urandom_range(32768) - 16384)};
            end else begin
                dir = {16'($urandom), 16'($urandom), 16'($urandom)};
            end
            write_register(REG_DIRECTION, 64'(dir));
            write_register(REG_SPINS_CCW, 64'($urandom_range(1)));
            write_register(REG_FLIPPED, 64'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: negative, zero, clamp edge, full-scale commands
        send_request(16'h8000, 16'hFFFF);
        send_request(16'hFFFF, 16'h0001);
        send_request(16'h0000, 16'h0000);
        send_request(16'h0001, 16'hFFFF);
        send_request(16'd1280, 16'hFFFF);
        send_request(16'd1281, 16'h0001);
        send_request(16'h7FFF, 16'h8000);
        send_request(16'd640, 16'hAAAA);
        send_request(16'h5555, 16'h5555);
        drain_results();

        // largest settings, non-unit direction, unmapped register ignored
        write_register(REG_MAX_THRUST, 64'd32767);
        write_register(REG_INV_COEF, 64'd16777215);
        write_register(REG_RATIO, 64'd65535);
        write_register(REG_POSITION, 64'h7FFF_8000_7FFF);
        write_register(REG_DIRECTION, 64'h8000_7FFF_8000);
        write_register(REG_SPINS_CCW, 64'd1);
        write_register(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(16'h7FFF, 16'hFFFF);
        send_request(16'h7FFF, 16'h0000);
        send_request(16'd12345, 16'h0001);
        send_request(16'hFFFB, 16'hFFFF);
        send_request(16'h0001, 16'h0001);
        drain_results();

        // zero coefficient: no speed, phase holds
        write_register(REG_FLIPPED, 64'd1);
        write_register(REG_INV_COEF, 64'd0);
        send_request(16'h7FFF, 16'hFFFF);
        send_request(16'd100, 16'd100);
        drain_results();

        write_register(REG_INV_COEF, 64'd1);
        write_register(REG_SPINS_CCW, 64'd0);
        write_register(REG_POSITION, 64'h8000_8000_8000);
        write_register(REG_DIRECTION, 64'h8000_8000_8000);
        send_request(16'h7FFF, 16'hFFFF);
        send_request(16'h0001, 16'h0001);
        send_request(16'h0002, 16'hFFFF);
        drain_results();

        write_register(REG_MAX_THRUST, 64'd0);
        send_request(16'h7FFF, 16'hFFFF);
        drain_results();

        // long receiver hold-off while requests keep coming
        write_register(REG_MAX_THRUST, 64'd1280);
        write_register(REG_INV_COEF, 64'd100000);
        hold_req <= 1'b1;
        repeat (PRESSURE_ITEMS) send_request(random_command(cur_max), random_step());
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            apply_settings(phase);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 59; end
                default: begin send_idle_pct = 30; recv_stall_pct <= 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_command(cur_max), random_step());
                if ($urandom_range(99) < send_idle_pct) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(MAX_GAP, 1)) @(posedge aclk);
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
src/rftq_pkg.sv
src/rotor_force_torque_step.sv
sim/rotor_step_checker.sv
sim/tb_rotor_force_torque_step.sv
